// ----- rtl/stsp_pkg.sv -----
// Package for the software timer slot pool: command codes, result limits
// and the slot entry and slot write types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stsp_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] remaining;
        logic              notify;
    } t_slot_entry;

    typedef struct packed {
        logic        wr;
        logic        clr;
        t_slot_entry entry;
    } t_slot_wr;

endpackage
`default_nettype wire

// ----- rtl/stsp_if.sv -----
// Valid/ready channel interfaces for command items and result items.
// Depends on stsp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface stsp_in_if;
    import stsp_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [ID_W-1:0]   owner_id;
    logic [TIME_W-1:0] period;
    logic              notify;

    modport source (output valid, output cmd, output owner_id, output period,
                    output notify, input ready);
    modport sink (input valid, input cmd, input owner_id, input period,
                  input notify, output ready);
    modport monitor (input valid, input ready, input cmd, input owner_id,
                     input period, input notify);
endinterface

interface stsp_out_if;
    import stsp_pkg::*;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              busy_res;
    logic [TIME_W-1:0] remaining;
    logic              expired_valid;
    logic [ID_W-1:0]   expired_id;
    logic              last;

    modport source (output valid, output accepted, output busy_res, output remaining,
                    output expired_valid, output expired_id, output last, input ready);
    modport sink (input valid, input accepted, input busy_res, input remaining,
                  input expired_valid, input expired_id, input last, output ready);
    modport monitor (input valid, input ready, input accepted, input busy_res,
                     input remaining, input expired_valid, input expired_id, input last);
endinterface
`default_nettype wire

// ----- rtl/stsp_slot_store.sv -----
// Slot store: entry memory with registered read and one active flop per slot.
// Depends on stsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stsp_slot_store
    import stsp_pkg::*;
#(
    parameter int SLOTS = 8,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IW-1:0]    i_rd_addr,
    output t_slot_entry           o_rd_entry,
    output logic [SLOTS-1:0]      o_active,
    input  wire logic [IW-1:0]    i_wr_addr,
    input  wire t_slot_wr         i_wr
);

    t_slot_entry      r_mem [SLOTS];
    t_slot_entry      r_rd;
    logic [SLOTS-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr) begin
            r_mem[i_wr_addr] <= i_wr.entry;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_wr.wr) begin
            r_active[i_wr_addr] <= 1'b1;
        end else if (i_wr.clr) begin
            r_active[i_wr_addr] <= 1'b0;
        end
    end

    assign o_rd_entry = r_rd;
    assign o_active   = r_active;

endmodule
`default_nettype wire

// ----- rtl/software_timer_slot_pool_unit.sv -----
// Software timer slot pool, top level. Walks the slots one per cycle while no
// tick result waits on the sink. Takes one item at a time: a new item is not taken
// until the walk ends and its final result is registered, set by the single slot walk over
// the slot memory port; a tick with several expiries waits on the sink between results.
// Reset: synchronous active low; all slots inactive, output empty.
// Depends on stsp_pkg, stsp_if and stsp_slot_store.
`timescale 1ns / 1ps
`default_nettype none
module software_timer_slot_pool_unit
    import stsp_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stsp_in_if.sink   i_in,
    stsp_out_if.source o_res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [1:0]        r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_period;
    logic              r_notify;
    logic              r_acc, n_acc;
    logic              r_busy, n_busy;
    logic [TIME_W-1:0] r_rem, n_rem;
    logic              r_pend_v, n_pend_v;
    logic [ID_W-1:0]   r_pend_id, n_pend_id;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              r_out_valid, n_out_valid;
    logic              r_out_acc, n_out_acc;
    logic              r_out_busy, n_out_busy;
    logic [TIME_W-1:0] r_out_rem, n_out_rem;
    logic              r_out_ev, n_out_ev;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    logic              r_out_last, n_out_last;

    logic [IW-1:0]     w_rd_addr;
    t_slot_entry       w_ent;
    logic [SLOTS-1:0]  w_active;
    t_slot_wr          w_wr;

    logic              w_act, w_match, w_expire, w_event, w_free, w_stall;
    logic              w_adv, w_last_slot, w_take;
    logic [ID_W-1:0]   w_owner;

    stsp_slot_store #(.SLOTS(SLOTS)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (w_rd_addr),
        .o_rd_entry (w_ent),
        .o_active   (w_active),
        .i_wr_addr  (r_idx),
        .i_wr       (w_wr)
    );

    assign w_take      = i_in.valid && (r_state == ST_IDLE);
    assign w_act       = w_active[r_idx];
    assign w_owner     = w_act ? w_ent.owner : '0;
    assign w_match     = (w_owner == r_id);
    assign w_expire    = (w_ent.remaining <= TIME_W'(1));
    assign w_event     = (r_cmd == CMD_TICK) && w_act && w_expire && w_ent.notify
                         && (r_cnt < CNT_W'(MAX_RESULTS));
    assign w_free      = !r_out_valid || o_res.ready;
    assign w_stall     = w_event && r_pend_v && !w_free;
    assign w_adv       = (r_state == ST_RUN) && !w_stall;
    assign w_last_slot = (r_idx == IW'(SLOTS - 1));

    always_comb begin
        if (w_adv) begin
            w_rd_addr = w_last_slot ? '0 : IW'(r_idx + 1'b1);
        end else if (r_state == ST_RUN) begin
            w_rd_addr = r_idx;
        end else begin
            w_rd_addr = '0;
        end
    end

    always_comb begin
        w_wr        = '0;
        n_state     = r_state;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_busy      = r_busy;
        n_rem       = r_rem;
        n_pend_v    = r_pend_v;
        n_pend_id   = r_pend_id;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_acc   = r_out_acc;
        n_out_busy  = r_out_busy;
        n_out_rem   = r_out_rem;
        n_out_ev    = r_out_ev;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state   = ST_RUN;
                    n_idx     = '0;
                    n_acc     = 1'b0;
                    n_busy    = 1'b0;
                    n_rem     = '0;
                    n_pend_v  = 1'b0;
                    n_pend_id = '0;
                    n_cnt     = '0;
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    case (r_cmd)
                        CMD_START: begin
                            if ((!w_act || w_match) && !r_acc) begin
                                w_wr.wr     = 1'b1;
                                w_wr.entry  = '{owner: r_id, remaining: r_period,
                                                notify: r_notify};
                                n_acc       = 1'b1;
                            end else if (w_act && w_match) begin
                                w_wr.clr = 1'b1;
                            end
                        end
                        CMD_STOP: begin
                            w_wr.clr = w_act && w_match;
                        end
                        CMD_QUERY: begin
                            if (w_match) begin
                                n_rem  = w_act ? w_ent.remaining : '0;
                                n_busy = r_busy || w_act;
                            end
                        end
                        CMD_TICK: begin
                            if (w_act && w_expire) begin
                                w_wr.clr = 1'b1;
                            end else if (w_act) begin
                                w_wr.wr    = 1'b1;
                                w_wr.entry = '{owner: w_ent.owner,
                                               remaining: w_ent.remaining - 1'b1,
                                               notify: w_ent.notify};
                            end
                            if (w_event) begin
                                n_pend_v  = 1'b1;
                                n_pend_id = w_ent.owner;
                                n_cnt     = r_cnt + 1'b1;
                                if (r_pend_v) begin
                                    n_out_valid = 1'b1;
                                    n_out_acc   = 1'b0;
                                    n_out_busy  = 1'b0;
                                    n_out_rem   = '0;
                                    n_out_ev    = 1'b1;
                                    n_out_id    = r_pend_id;
                                    n_out_last  = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_idx = w_last_slot ? '0 : IW'(r_idx + 1'b1);
                    if (w_last_slot) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_acc;
                    n_out_busy  = r_busy;
                    n_out_rem   = r_rem;
                    n_out_ev    = r_pend_v;
                    n_out_id    = r_pend_id;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd    <= i_in.cmd;
            r_id     <= i_in.owner_id;
            r_period <= i_in.period;
            r_notify <= i_in.notify;
        end
        r_idx      <= n_idx;
        r_acc      <= n_acc;
        r_busy     <= n_busy;
        r_rem      <= n_rem;
        r_pend_v   <= n_pend_v;
        r_pend_id  <= n_pend_id;
        r_cnt      <= n_cnt;
        r_out_acc  <= n_out_acc;
        r_out_busy <= n_out_busy;
        r_out_rem  <= n_out_rem;
        r_out_ev   <= n_out_ev;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.accepted      = r_out_acc;
    assign o_res.busy_res      = r_out_busy;
    assign o_res.remaining     = r_out_rem;
    assign o_res.expired_valid = r_out_ev;
    assign o_res.expired_id    = r_out_id;
    assign o_res.last          = r_out_last;

endmodule
`default_nettype wire

// ----- rtl/stsp_checker.sv -----
// Port-level checks for the software timer slot pool, bound to the top level.
// Depends on stsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stsp_checker
    import stsp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_res_valid,
    input wire logic              i_res_ready,
    input wire logic              i_res_accepted,
    input wire logic              i_res_busy,
    input wire logic [TIME_W-1:0] i_res_remaining,
    input wire logic              i_res_expired_valid,
    input wire logic [ID_W-1:0]   i_res_expired_id,
    input wire logic              i_res_last
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_remaining)
        && $stable(i_res_expired_id) && $stable(i_res_last))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while another is in progress");

    a_expiry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_expired_valid |-> !i_res_accepted && !i_res_busy
        && (i_res_remaining == '0))
        else $error("expiry result carries command fields");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_expired_valid |-> i_res_last)
        else $error("non-expiry result not final");

    a_ready_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_last |-> !i_in_ready)
        else $error("ready before final result produced");

endmodule

bind software_timer_slot_pool_unit stsp_checker u_stsp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_res_accepted      (o_res.accepted),
    .i_res_busy          (o_res.busy_res),
    .i_res_remaining     (o_res.remaining),
    .i_res_expired_valid (o_res.expired_valid),
    .i_res_expired_id    (o_res.expired_id),
    .i_res_last          (o_res.last)
);
`default_nettype wire
